// File: rtl/tksti_pkg.sv
package tksti_pkg;

    localparam int unsigned SCORE_W = 32;
    localparam int unsigned TIME_W  = 24;
    localparam int unsigned TAG_W   = 32;
    localparam int unsigned RANK_W  = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DUMP   = 1'b1;

    typedef struct packed {
        logic                      op;
        logic signed [SCORE_W-1:0] score;
        logic [TIME_W-1:0]         finish_time;
        logic [TAG_W-1:0]          player_tag;
    } t_in_item;

    typedef struct packed {
        logic [RANK_W-1:0]         rank_slot;
        logic                      slot_valid;
        logic signed [SCORE_W-1:0] out_score;
        logic [TIME_W-1:0]         out_time;
        logic [TAG_W-1:0]          out_tag;
        logic                      last;
    } t_out_item;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [TIME_W-1:0]         ftime;
        logic [TAG_W-1:0]          tag;
    } t_entry;

    // per-cycle command to every cell of the chain
    typedef struct packed {
        logic ins;  // insert the broadcast entry, worse entries move down
        logic rot;  // rotate the chain one slot toward cell 0
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INS,
        ST_DUMP
    } t_state;

    // a strictly above b: higher score, or equal score and lower time
    function automatic logic ranks_above(input t_entry a, input t_entry b);
        logic res;
        if (a.score != b.score) begin
            res = (a.score > b.score);
        end else begin
            res = (a.ftime < b.ftime);
        end
        return res;
    endfunction

endpackage

// File: rtl/tksti_cell.sv
module tksti_cell
    import tksti_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_new,
    input  t_entry    i_prev_ent,
    input  logic      i_prev_valid,
    input  logic      i_prev_above,
    input  t_entry    i_next_ent,
    input  logic      i_next_valid,
    output t_entry    o_ent,
    output logic      o_valid,
    output logic      o_above
);

    t_entry r_ent;
    t_entry n_ent;
    logic   r_valid;
    logic   n_valid;

    // an empty slot is worse than any entry
    assign o_above = !r_valid || ranks_above(i_new, r_ent);

    always_comb begin
        n_ent   = r_ent;
        n_valid = r_valid;
        if (i_ctl.rot) begin
            n_ent   = i_next_ent;
            n_valid = i_next_valid;
        end else if (i_ctl.ins) begin
            if (i_prev_above) begin
                n_ent   = i_prev_ent;
                n_valid = i_prev_valid;
            end else if (o_above) begin
                n_ent   = i_new;
                n_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    assign o_ent   = r_ent;
    assign o_valid = r_valid;

endmodule

// File: rtl/top_k_score_table_insert_top.sv
// sorted top-k score table built as a chain of slot cells
// command channel: an item (op, score, finish_time, player_tag) is taken at a
// rising edge with i_start high and o_busy low
// result channel: each result sits on o_result for one cycle with o_strobe
// high; there is no back-pressure, the receiver must take it then
// insert (op 0): the item is broadcast to all cells, each cell compares it
// with its own entry in parallel, and the chain moves worse entries down one
// slot in the same cycle; a single registered result gives the
// slot taken, or TABLE_DEPTH with slot_valid low if the item was dropped
// dump (op 1): the chain rotates toward cell 0 once a cycle and cell 0 is
// reported each time; TABLE_DEPTH results follow on consecutive cycles,
// with last high on the final one; after the full turn the table is back
// in place
// a new command is accepted only in the idle state, so the next item waits
// until an insert or a full dump has finished
// reset clears the slot valid bits (empty table) and the control state;
// the slot payload is never cleared since an empty slot is reported as zero
module top_k_score_table_insert_top
    import tksti_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    output logic      o_busy,
    input  t_in_item  i_item,
    output logic      o_strobe,
    output t_out_item o_result
);

    // wide enough to hold TABLE_DEPTH itself (the dropped code)
    localparam int unsigned RW = $clog2(TABLE_DEPTH + 1);

    t_state r_state;
    t_state n_state;

    // command register feeding the chain
    t_entry r_new;

    // dump position
    logic [RW-1:0] r_cnt;
    logic [RW-1:0] n_cnt;

    t_out_item r_result;
    t_out_item n_result;
    logic      r_strobe;
    logic      n_strobe;

    t_cell_ctl w_ctl;

    // chain wires
    t_entry                 w_ent [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_valid;
    logic [TABLE_DEPTH-1:0] w_above;

    logic [RW-1:0]   w_pos;
    logic [RW+4:0]   w_pos_wide;
    logic [RW+4:0]   w_cnt_wide;
    logic            w_accept;
    logic            w_dump_end;

    assign w_accept   = i_start && (r_state == ST_IDLE);
    assign w_dump_end = (r_cnt == RW'(TABLE_DEPTH - 1));

    // cell chain: cell i hands its entry down on insert and up on rotate
    for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
        t_entry w_prev_ent;
        logic   w_prev_valid;
        logic   w_prev_above;

        if (gi == 0) begin : g_head
            assign w_prev_ent   = '0;
            assign w_prev_valid = 1'b0;
            assign w_prev_above = 1'b0;
        end else begin : g_body
            assign w_prev_ent   = w_ent[gi-1];
            assign w_prev_valid = w_valid[gi-1];
            assign w_prev_above = w_above[gi-1];
        end

        tksti_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_new        (r_new),
            .i_prev_ent   (w_prev_ent),
            .i_prev_valid (w_prev_valid),
            .i_prev_above (w_prev_above),
            .i_next_ent   (w_ent[(gi + 1) % TABLE_DEPTH]),
            .i_next_valid (w_valid[(gi + 1) % TABLE_DEPTH]),
            .o_ent        (w_ent[gi]),
            .o_valid      (w_valid[gi]),
            .o_above      (w_above[gi])
        );
    end

    // first cell the new entry beats; above flags are monotone along the chain
    always_comb begin
        w_pos = RW'(TABLE_DEPTH);
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (w_above[i]) begin
                w_pos = RW'(i);
            end
        end
    end

    // rank codes are reported on five bits
    assign w_pos_wide = {5'b0, w_pos};
    assign w_cnt_wide = {5'b0, r_cnt};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = (i_item.op == OP_DUMP) ? ST_DUMP : ST_INS;
                end
            end
            ST_INS: begin
                n_state = ST_IDLE;
            end
            ST_DUMP: begin
                if (w_dump_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // chain commands and result
    always_comb begin
        w_ctl    = '0;
        n_cnt    = r_cnt;
        n_result = r_result;
        n_strobe = 1'b0;
        case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
            end
            ST_INS: begin
                w_ctl.ins           = 1'b1;
                n_strobe            = 1'b1;
                n_result.rank_slot  = w_pos_wide[4:0];
                n_result.slot_valid = |w_above;
                n_result.out_score  = (|w_above) ? r_new.score : '0;
                n_result.out_time   = (|w_above) ? r_new.ftime : '0;
                n_result.out_tag    = (|w_above) ? r_new.tag   : '0;
                n_result.last       = 1'b1;
            end
            ST_DUMP: begin
                w_ctl.rot           = 1'b1;
                n_strobe            = 1'b1;
                n_cnt               = r_cnt + RW'(1);
                n_result.rank_slot  = w_cnt_wide[4:0];
                n_result.slot_valid = w_valid[0];
                n_result.out_score  = w_valid[0] ? w_ent[0].score : '0;
                n_result.out_time   = w_valid[0] ? w_ent[0].ftime : '0;
                n_result.out_tag    = w_valid[0] ? w_ent[0].tag   : '0;
                n_result.last       = w_dump_end;
            end
            default: begin
                w_ctl = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (w_accept) begin
            r_new.score <= i_item.score;
            r_new.ftime <= i_item.finish_time;
            r_new.tag   <= i_item.player_tag;
        end
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

`ifndef SYNTH
    // a result only ever follows a cycle of work
    a_strobe_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state != ST_IDLE))
        else $error("result without preceding work cycle");

    // at rest the occupied slots form a solid run from cell 0
    a_valid_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (((w_valid + TABLE_DEPTH'(1)) & w_valid) == '0))
        else $error("slot valid bits not contiguous");

    // an insert into a table with room always grows it by one
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INS) && !w_valid[TABLE_DEPTH-1]
        |=> $countones(w_valid) == $past($countones(w_valid)) + 1)
        else $error("insert did not add an entry");

    // a dump ends with last on its final result
    a_dump_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DUMP) && w_dump_end |=> o_strobe && o_result.last)
        else $error("dump did not end with last");
`endif

endmodule
